// ----- hdl/sbm3_pkg.sv -----
// shared types and constants for the sparse block map
`default_nettype none

package sbm3_pkg;

   localparam int ADDR_W   = 37;
   localparam int HANDLE_W = 16;
   localparam int FBN_W    = 24;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] byte_address;
      logic              allocate;
   } req_type;

   typedef struct packed {
      logic                is_zero_block;
      logic [HANDLE_W-1:0] block_handle;
      logic                newly_allocated;
      logic                fetch_needed;
      logic [FBN_W-1:0]    fetch_block_number;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic accept;
      logic rd_mid;
      logic rd_leaf;
      logic commit;
      logic push;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic slot_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- hdl/sbm3_ctrl.sv -----
// controller state machine for the sparse block map walk
`default_nettype none

module sbm3_ctrl import sbm3_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat_i,
   output cmd_type       cmd_o
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_TOP   = 3'd2;
   localparam logic [2:0] ST_MID   = 3'd3;
   localparam logic [2:0] ST_LEAF  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd_o.clear = 1'b1;
            if (stat_i.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_o.accept = 1'b1;
               state_in     = ST_TOP;
            end
         end
         ST_TOP: begin
            cmd_o.rd_mid = 1'b1;
            state_in     = ST_MID;
         end
         ST_MID: begin
            cmd_o.rd_leaf = 1'b1;
            state_in      = ST_LEAF;
         end
         ST_LEAF: begin
            cmd_o.commit = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (stat_i.slot_free) begin
               cmd_o.push = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

`ifndef SYNTHESIS
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd_o.clear, cmd_o.accept, cmd_o.rd_mid, cmd_o.rd_leaf,
                cmd_o.commit, cmd_o.push}))
      else $error("more than one datapath command at once");
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      cmd_o.accept |=> cmd_o.rd_mid ##1 cmd_o.rd_leaf ##1 cmd_o.commit)
      else $error("table walk out of order");
`endif

endmodule

`default_nettype wire

// ----- hdl/sbm3_dp.sv -----
// datapath: pointer tables, bump counters, result and output registers
`default_nettype none

module sbm3_dp import sbm3_pkg::*; #(
   parameter int BLOCK_BITS   = 13,
   parameter int LEVEL_BITS   = 8,
   parameter int MIDDLE_NODES = 256,
   parameter int LEAF_NODES   = 256,
   parameter int DATA_BLOCKS  = 65536
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd_i,
   output stat_type     stat_o,
   input  wire req_type req_data,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data,
   input  wire logic    rsp_stall,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int FAN        = 1 << LEVEL_BITS;
   localparam int MID_DEPTH  = MIDDLE_NODES * FAN;
   localparam int LEAF_DEPTH = LEAF_NODES * FAN;
   localparam int MID_AW     = $clog2(MID_DEPTH);
   localparam int LEAF_AW    = $clog2(LEAF_DEPTH);
   localparam int MN_W       = (MIDDLE_NODES > 1) ? $clog2(MIDDLE_NODES) : 1;
   localparam int LN_W       = (LEAF_NODES > 1) ? $clog2(LEAF_NODES) : 1;
   localparam int HW         = $clog2(DATA_BLOCKS);
   localparam int MNC_W      = $clog2(MIDDLE_NODES + 1);
   localparam int LNC_W      = $clog2(LEAF_NODES + 1);
   localparam int HC_W       = $clog2(DATA_BLOCKS + 1);
   localparam int CLR_DEPTH  = (MID_DEPTH > LEAF_DEPTH) ? MID_DEPTH : LEAF_DEPTH;
   localparam int CLR_W      = $clog2(CLR_DEPTH);

   // table entries: valid bit over node number or handle
   logic [MN_W:0] top_mem  [FAN];
   logic [LN_W:0] mid_mem  [MID_DEPTH];
   logic [HW:0]   leaf_mem [LEAF_DEPTH];

   req_type       req_ff;
   logic [MN_W:0] top_q_ff;
   logic [LN_W:0] mid_q_ff;
   logic [HW:0]   leaf_q_ff;

   logic [MNC_W-1:0] nm_ff, nm_in;
   logic [LNC_W-1:0] nl_ff, nl_in;
   logic [HC_W-1:0]  nd_ff, nd_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic             backing_ff, backing_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_data_ff;

   // address decode of the latched transaction, and of the incoming request's top index
   logic [ADDR_W-1:0]     blk;
   logic [ADDR_W-1:0]     blk_new;
   logic [LEVEL_BITS-1:0] i0, i1, i2, i2_new;
   logic                  oor;

   assign blk     = req_ff.byte_address >> BLOCK_BITS;
   assign blk_new = req_data.byte_address >> BLOCK_BITS;
   assign i0      = blk[LEVEL_BITS-1:0];
   assign i1      = blk[2*LEVEL_BITS-1:LEVEL_BITS];
   assign i2      = blk[3*LEVEL_BITS-1:2*LEVEL_BITS];
   assign i2_new  = blk_new[3*LEVEL_BITS-1:2*LEVEL_BITS];
   assign oor     = |(blk >> (3*LEVEL_BITS));

   logic            top_v, mid_v, leaf_v;
   logic [MN_W-1:0] top_node;
   logic [LN_W-1:0] mid_node;
   logic [HW-1:0]   leaf_handle;

   assign top_v       = top_q_ff[MN_W];
   assign top_node    = top_q_ff[MN_W-1:0];
   assign mid_v       = mid_q_ff[LN_W];
   assign mid_node    = mid_q_ff[LN_W-1:0];
   assign leaf_v      = leaf_q_ff[HW];
   assign leaf_handle = leaf_q_ff[HW-1:0];

   // allocation decision
   logic need_mid, need_leaf, need_data, hit, alloc, exhaust, do_alloc;

   assign need_mid  = !top_v;
   assign need_leaf = need_mid || !mid_v;
   assign need_data = need_leaf || !leaf_v;
   assign hit       = !oor && !need_data;
   assign alloc     = req_ff.allocate || backing_ff;
   assign exhaust   = (need_mid && (nm_ff == MNC_W'(MIDDLE_NODES)))
                   || (need_leaf && (nl_ff == LNC_W'(LEAF_NODES)))
                   || (nd_ff == HC_W'(DATA_BLOCKS));
   assign do_alloc  = !oor && need_data && alloc && !exhaust;

   logic [MN_W-1:0] mid_sel;
   logic [LN_W-1:0] leaf_sel;

   assign mid_sel  = need_mid ? nm_ff[MN_W-1:0] : top_node;
   assign leaf_sel = need_leaf ? nl_ff[LN_W-1:0] : mid_node;

   // write ports: clearing sweep or commit
   logic                  top_we, mid_we, leaf_we;
   logic [LEVEL_BITS-1:0] top_wa;
   logic [MID_AW-1:0]     mid_wa;
   logic [LEAF_AW-1:0]    leaf_wa;
   logic [MN_W:0]         top_wd;
   logic [LN_W:0]         mid_wd;
   logic [HW:0]           leaf_wd;

   always_comb begin
      if (cmd_i.clear) begin
         top_we  = ({1'b0, clr_ff} < (CLR_W+1)'(FAN));
         mid_we  = ({1'b0, clr_ff} < (CLR_W+1)'(MID_DEPTH));
         leaf_we = ({1'b0, clr_ff} < (CLR_W+1)'(LEAF_DEPTH));
         top_wa  = LEVEL_BITS'(clr_ff);
         mid_wa  = MID_AW'(clr_ff);
         leaf_wa = LEAF_AW'(clr_ff);
         top_wd  = '0;
         mid_wd  = '0;
         leaf_wd = '0;
      end else begin
         top_we  = cmd_i.commit && do_alloc && need_mid;
         mid_we  = cmd_i.commit && do_alloc && need_leaf;
         leaf_we = cmd_i.commit && do_alloc;
         top_wa  = i2;
         mid_wa  = MID_AW'({mid_sel, i1});
         leaf_wa = LEAF_AW'({leaf_sel, i0});
         top_wd  = {1'b1, nm_ff[MN_W-1:0]};
         mid_wd  = {1'b1, nl_ff[LN_W-1:0]};
         leaf_wd = {1'b1, nd_ff[HW-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (top_we) begin
         top_mem[top_wa] <= top_wd;
      end
      if (cmd_i.accept) begin
         top_q_ff <= top_mem[i2_new];
      end
   end

   always_ff @(posedge clock) begin
      if (mid_we) begin
         mid_mem[mid_wa] <= mid_wd;
      end
      if (cmd_i.rd_mid) begin
         mid_q_ff <= mid_mem[MID_AW'({top_node, i1})];
      end
   end

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[leaf_wa] <= leaf_wd;
      end
      if (cmd_i.rd_leaf) begin
         leaf_q_ff <= leaf_mem[LEAF_AW'({mid_node, i0})];
      end
   end

   // result of the walk
   logic [HW+HANDLE_W-1:0] hit_wide, new_wide;

   assign hit_wide = {{HANDLE_W{1'b0}}, leaf_handle};
   assign new_wide = {{HANDLE_W{1'b0}}, nd_ff[HW-1:0]};

   always_comb begin
      res_in                    = '0;
      res_in.is_zero_block      = !(hit || do_alloc);
      res_in.newly_allocated    = do_alloc;
      res_in.fetch_needed       = do_alloc && backing_ff;
      res_in.fetch_block_number = (do_alloc && backing_ff) ? blk[FBN_W-1:0] : '0;
      if (hit) begin
         res_in.block_handle = hit_wide[HANDLE_W-1:0];
      end else if (do_alloc) begin
         res_in.block_handle = new_wide[HANDLE_W-1:0];
      end
      priority if (oor) begin
         res_in.status = STATUS_RANGE;
      end else if (need_data && alloc && exhaust) begin
         res_in.status = STATUS_EXHAUSTED;
      end else begin
         res_in.status = STATUS_OK;
      end
   end

   // control registers
   always_comb begin
      nm_in        = nm_ff;
      nl_in        = nl_ff;
      nd_in        = nd_ff;
      clr_in       = clr_ff;
      backing_in   = backing_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd_i.clear) begin
         clr_in = clr_ff + CLR_W'(1);
      end
      if (cmd_i.commit && do_alloc) begin
         nd_in = nd_ff + HC_W'(1);
         if (need_mid) begin
            nm_in = nm_ff + MNC_W'(1);
         end
         if (need_leaf) begin
            nl_in = nl_ff + LNC_W'(1);
         end
      end
      if (csr_write_enable) begin
         backing_in = csr_write_data;
      end
      if (cmd_i.push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_ff        <= '0;
         nl_ff        <= '0;
         nd_ff        <= '0;
         clr_ff       <= '0;
         backing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nm_ff        <= nm_in;
         nl_ff        <= nl_in;
         nd_ff        <= nd_in;
         clr_ff       <= clr_in;
         backing_ff   <= backing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.accept) begin
         req_ff <= req_data;
      end
      if (cmd_i.commit) begin
         res_ff <= res_in;
      end
      if (cmd_i.push) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign stat_o.clear_done = (clr_ff == CLR_W'(CLR_DEPTH - 1));
   assign stat_o.slot_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;

`ifndef SYNTHESIS
   a_counter_limits: assert property (@(posedge clock) disable iff (reset)
      (nm_ff <= MNC_W'(MIDDLE_NODES)) && (nl_ff <= LNC_W'(LEAF_NODES))
      && (nd_ff <= HC_W'(DATA_BLOCKS)))
      else $error("bump counter past its limit");
   a_handle_bump: assert property (@(posedge clock) disable iff (reset)
      cmd_i.commit && do_alloc |=> nd_ff == $past(nd_ff) + HC_W'(1))
      else $error("data handle not taken on allocation");
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.is_zero_block |->
      (rsp_data_ff.block_handle == '0) && !rsp_data_ff.newly_allocated)
      else $error("zero block result carries a handle");
`endif

endmodule

`default_nettype wire

// ----- hdl/sparse_block_map_three_level_top.sv -----
// top level of the three-level sparse block map with allocate on write
//
//   port group   dir   handshake                payload
//   req_*        in    req_valid / req_stall    req_type: byte_address, allocate
//   rsp_*        out   rsp_valid / rsp_stall    rsp_type: handle, flags, status
//   csr_*        in    csr_write_enable         backing_present bit
//
// a transaction goes through these steps in order:
// accept with top read, middle read, leaf read, decide and write back, load result
// the three table reads are registered and each depends on the one before; one walk at a time
// the next transaction is taken while the previous result waits under rsp_stall
// after reset a clearing pass over the max(MIDDLE_NODES, LEAF_NODES) << LEVEL_BITS entries
// of the deepest table (65536 at default sizes) empties all tables before req_stall drops
`default_nettype none

module sparse_block_map_three_level_top import sbm3_pkg::*; #(
   parameter int BLOCK_BITS   = 13,
   parameter int LEVEL_BITS   = 8,
   parameter int MIDDLE_NODES = 256,
   parameter int LEAF_NODES   = 256,
   parameter int DATA_BLOCKS  = 65536
) (
   input  wire logic    clock,
   input  wire logic    reset,
   // request channel
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   // response channel
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   // configuration register
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);

   // command and status between the controller and the datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: clearing pass, table walk, commit, output handoff
   sbm3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   // tables, bump counters, decision logic and the output register
   sbm3_dp #(
      .BLOCK_BITS   (BLOCK_BITS),
      .LEVEL_BITS   (LEVEL_BITS),
      .MIDDLE_NODES (MIDDLE_NODES),
      .LEAF_NODES   (LEAF_NODES),
      .DATA_BLOCKS  (DATA_BLOCKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd_i            (cmd),
      .stat_o           (stat),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/sparse_block_map_three_level_top_tb.sv -----
// self-checking testbench for the three-level sparse block map
`default_nettype none

module sparse_block_map_three_level_top_tb;
   import sbm3_pkg::*;

   // block sizes, kept at the defaults of the top level
   localparam int BLOCK_BITS   = 13;
   localparam int LEVEL_BITS   = 8;
   localparam int MIDDLE_NODES = 256;
   localparam int LEAF_NODES   = 256;
   localparam int DATA_BLOCKS  = 65536;
   localparam int BLK_W        = ADDR_W - BLOCK_BITS;
   localparam int FAN          = 1 << LEVEL_BITS;

   // budget for the clearing pass plus about 1600 transactions at worst,
   // taken several times over
   localparam int unsigned CYCLE_LIMIT = 600000;

   // shadow copy of the map: three radix tables, bump counters and the
   // backing store bit, plus the responses still owed by the block
   class map_shadow;
      bit                     backing;
      logic [LEVEL_BITS:0]    top_tab [FAN];                   // {valid, middle node}
      logic [LEVEL_BITS:0]    middle_tab [MIDDLE_NODES * FAN]; // {valid, leaf node}
      logic [HANDLE_W:0]      leaf_tab [LEAF_NODES * FAN];     // {valid, handle}
      int unsigned            next_middle;
      int unsigned            next_leaf;
      int unsigned            next_handle;
      rsp_type                pending_rsp [$];
      int unsigned            error_count;

      function new();
         backing     = 1'b0;
         next_middle = 0;
         next_leaf   = 0;
         next_handle = 0;
         error_count = 0;
         foreach (top_tab[i]) top_tab[i] = '0;
         foreach (middle_tab[i]) middle_tab[i] = '0;
         foreach (leaf_tab[i]) leaf_tab[i] = '0;
      endfunction

      // walk the tables for one accepted request and queue the response
      function void note_request(req_type r);
         rsp_type               e;
         logic [BLK_W-1:0]      blk;
         logic [LEVEL_BITS-1:0] i0, i1, i2, mid, leaf;
         logic [LEVEL_BITS:0]   te, me;
         logic [HANDLE_W:0]     le;
         bit                    need_mid, need_leaf, grow;
         e = '0;
         e.is_zero_block = 1'b1;
         blk = r.byte_address[ADDR_W-1:BLOCK_BITS];
         {i2, i1, i0} = blk[3*LEVEL_BITS-1:0];
         grow = r.allocate || backing;
         me = '0;
         le = '0;
         te = top_tab[i2];
         need_mid = !te[LEVEL_BITS];
         if (!need_mid) me = middle_tab[{te[LEVEL_BITS-1:0], i1}];
         need_leaf = need_mid || !me[LEVEL_BITS];
         if (!need_leaf) le = leaf_tab[{me[LEVEL_BITS-1:0], i0}];
         if ((blk >> (3*LEVEL_BITS)) != 0) begin
            e.status = STATUS_RANGE;
         end else if (!need_leaf && le[HANDLE_W]) begin
            e.is_zero_block = 1'b0;
            e.block_handle  = le[HANDLE_W-1:0];
         end else if (grow) begin
            if ((need_mid && next_middle >= MIDDLE_NODES) ||
                (need_leaf && next_leaf >= LEAF_NODES) ||
                next_handle >= DATA_BLOCKS) begin
               e.status = STATUS_EXHAUSTED;
            end else begin
               if (need_mid) begin
                  mid = next_middle[LEVEL_BITS-1:0];
                  next_middle++;
                  top_tab[i2] = {1'b1, mid};
               end else begin
                  mid = te[LEVEL_BITS-1:0];
               end
               if (need_leaf) begin
                  leaf = next_leaf[LEVEL_BITS-1:0];
                  next_leaf++;
                  middle_tab[{mid, i1}] = {1'b1, leaf};
               end else begin
                  leaf = me[LEVEL_BITS-1:0];
               end
               leaf_tab[{leaf, i0}] = {1'b1, next_handle[HANDLE_W-1:0]};
               e.is_zero_block      = 1'b0;
               e.block_handle       = next_handle[HANDLE_W-1:0];
               e.newly_allocated    = 1'b1;
               e.fetch_needed       = backing;
               e.fetch_block_number = backing ? blk[FBN_W-1:0] : '0;
               next_handle++;
            end
         end
         pending_rsp.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("response with no transaction outstanding: %h", a);
            error_count++;
            return;
         end
         e = pending_rsp.pop_front();
         compare_field("is_zero_block", e.is_zero_block, a.is_zero_block);
         compare_field("block_handle", e.block_handle, a.block_handle);
         compare_field("newly_allocated", e.newly_allocated, a.newly_allocated);
         compare_field("fetch_needed", e.fetch_needed, a.fetch_needed);
         compare_field("fetch_block_number", e.fetch_block_number, a.fetch_block_number);
         compare_field("status", e.status, a.status);
      endfunction
   endclass

   // every input known from time zero, reset held from the start
   logic    clock            = 1'b0;
   logic    reset            = 1'b1;
   logic    req_valid        = 1'b0;
   logic    req_stall;
   req_type req_data         = '0;
   logic    rsp_valid;
   logic    rsp_stall        = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data   = 1'b0;

   map_shadow        shadow;
   int unsigned      send_idle_pct  = 24;
   int unsigned      recv_stall_pct = 70;
   int unsigned      cycle_count    = 0;
   logic [BLK_W-1:0] block_pool [$];

   sparse_block_map_three_level_top #(
      .BLOCK_BITS   (BLOCK_BITS),
      .LEVEL_BITS   (LEVEL_BITS),
      .MIDDLE_NODES (MIDDLE_NODES),
      .LEAF_NODES   (LEAF_NODES),
      .DATA_BLOCKS  (DATA_BLOCKS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // a response transaction completes on a rising edge with valid high and stall low
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) shadow.check_response(rsp_data);
   end

   // hang guard, covers the clearing pass after reset too
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic req_type make_req(logic [BLK_W-1:0] blk,
                                        logic [BLOCK_BITS-1:0] offset, logic alloc);
      req_type r;
      r.byte_address = {blk, offset};
      r.allocate     = alloc;
      return r;
   endfunction

   // called at a falling edge; valid stays high on return so the next
   // transaction can follow back to back
   task automatic send_request(input req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      shadow.note_request(r);
      @(negedge clock);
   endtask

   task automatic end_requests();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (shadow.pending_rsp.size() != 0) @(negedge clock);
   endtask

   // only while nothing is in flight
   task automatic write_backing(input bit value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow.backing = value;
   endtask

   // random traffic built around blocks already touched, so that hits,
   // siblings in an existing leaf and new leaves under an existing middle
   // node all show up, next to fresh addresses that use up leaf nodes
   task automatic run_random(input int unsigned count);
      req_type          r;
      logic [BLK_W-1:0] blk;
      int unsigned      pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         r.byte_address = ADDR_W'({$urandom, $urandom});
         r.allocate     = 1'($urandom_range(1));
         if (block_pool.size() != 0 && pick < 60) begin
            blk = block_pool[$urandom_range(block_pool.size() - 1)];
            // sibling block in the same leaf node
            if (pick >= 30) blk[LEVEL_BITS-1:0] = LEVEL_BITS'($urandom);
            // new leaf under the same middle node
            if (pick >= 50) blk[2*LEVEL_BITS-1:LEVEL_BITS] = LEVEL_BITS'($urandom);
            r.byte_address[ADDR_W-1:BLOCK_BITS] = blk;
         end
         blk = r.byte_address[ADDR_W-1:BLOCK_BITS];
         if (block_pool.size() < 64) block_pool.push_back(blk);
         else block_pool[$urandom_range(63)] = blk;
         send_request(r);
      end
   endtask

   initial begin
      shadow = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed part without a backing store
      write_backing(1'b0);
      send_request(make_req(24'h000000, 13'h0000, 1'b0)); // lookup miss on empty map
      send_request(make_req(24'h000000, 13'h0000, 1'b1)); // builds all three levels
      send_request(make_req(24'h000000, 13'h1fff, 1'b0)); // hit, top offset ignored
      send_request(make_req(24'hffffff, 13'h1fff, 1'b1)); // highest address
      send_request(make_req(24'hffffff, 13'h0000, 1'b0)); // hit
      send_request(make_req(24'hffff00, 13'h0000, 1'b0)); // leaf present, block absent
      send_request(make_req(24'hffff00, 13'h0aaa, 1'b1)); // new block in existing leaf
      send_request(make_req(24'hff0000, 13'h0000, 1'b0)); // middle present, leaf absent
      send_request(make_req(24'hff00ff, 13'h1555, 1'b1)); // new leaf under existing middle
      send_request(make_req(24'h00ff00, 13'h0000, 1'b1)); // new leaf under top index 0
      send_request(make_req(24'h555555, 13'h1555, 1'b1));
      send_request(make_req(24'haaaaaa, 13'h0aaa, 1'b0)); // top entry absent
      end_requests();
      wait_drained();

      // backing store attached: allocation forced, fetch requested
      write_backing(1'b1);
      send_request(make_req(24'haaaaaa, 13'h0aaa, 1'b0)); // forced allocation with fetch
      send_request(make_req(24'haaaaaa, 13'h0000, 1'b1)); // hit, no fetch
      send_request(make_req(24'h123456, 13'h1fff, 1'b1));
      send_request(make_req(24'hffffff, 13'h0000, 1'b0));
      send_request(make_req(24'h000000, 13'h0000, 1'b0));
      end_requests();
      wait_drained();
      // the address field is exactly as wide as three radix levels plus the
      // offset, so an out-of-range block number cannot be formed here

      // sender idles lightly, receiver stalls heavily
      run_random(517);
      end_requests();
      wait_drained();

      // roles swapped, lookups do not allocate without a backing store
      write_backing(1'b0);
      send_idle_pct  = 70;
      recv_stall_pct = 24;
      run_random(517);
      end_requests();
      wait_drained();

      // full rate on both sides
      write_backing(1'b1);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(516);
      end_requests();
      wait_drained();

      // let any stray response show up
      repeat (20) @(negedge clock);
      if (shadow.error_count == 0 && shadow.pending_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
